>>> design/dsm_pkg.sv
`default_nettype none
package dsm_pkg;

  // Field widths of the request and result channels
  localparam int OP_W      = 1;
  localparam int IDX_W     = 16;
  localparam int LEN_W     = 17;
  localparam int FREQ_W    = 20;
  localparam int VEL_W     = 17;
  localparam int RATE_W    = 18;
  localparam int SMP_W     = 16;

  // Datapath widths
  localparam int SPAN_W    = 22;  // 16 * sample rate
  localparam int MUL_A_W   = 32;
  localparam int MUL_B_W   = 20;
  localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
  localparam int PH_PROD_W = 36;  // frequency * offset
  localparam int AMP_DVD_W = 33;  // (mag * (L-n) * vel) >> 16
  localparam int STEP_W    = 6;   // divider step count

  // Operation codes
  localparam logic OP_ACCUM = 1'b0;
  localparam logic OP_READ  = 1'b1;

  // Sine constants
  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q15     = 64'd32768;
  localparam logic [15:0] SINE_ONE    = 16'h8000;

  // Command to the shared divider
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

endpackage
`default_nettype wire

>>> design/dsm_if.sv
`default_nettype none
interface dsm_in_if import dsm_pkg::*;;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [IDX_W-1:0] sample_index;
  logic [IDX_W-1:0] note_start;
  logic [LEN_W-1:0] note_length;
  logic [FREQ_W-1:0] frequency;
  logic [VEL_W-1:0] velocity;
  modport source (output valid, operation, sample_index, note_start, note_length,
                  frequency, velocity, input ready);
  modport sink (input valid, operation, sample_index, note_start, note_length,
                frequency, velocity, output ready);
endinterface

interface dsm_out_if import dsm_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [SMP_W-1:0] sample;
  logic                    in_note;
  modport source (output valid, sample, in_note, input ready);
  modport sink (input valid, sample, in_note, output ready);
endinterface

interface dsm_cfg_if import dsm_pkg::*;;
  logic              valid;
  logic              ready;
  logic [RATE_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

>>> design/dsm_mul.sv
`default_nettype none
module dsm_mul import dsm_pkg::*; (
  input  wire logic               clk,
  input  wire logic [MUL_A_W-1:0] a,
  input  wire logic [MUL_B_W-1:0] b,
  output logic      [MUL_P_W-1:0] prod
);

  logic [MUL_P_W-1:0] prod_r;

  // Register the product every cycle
  always_ff @(posedge clk) begin
    prod_r <= MUL_P_W'(a) * MUL_P_W'(b);
  end

  assign prod = prod_r;

endmodule
`default_nettype wire

>>> design/dsm_div.sv
`default_nettype none
module dsm_div import dsm_pkg::*; #(
  parameter int DVD_W = 48
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire div_cmd_t          cmd,
  input  wire logic [DVD_W-1:0]  dividend,
  input  wire logic [SPAN_W-1:0] divisor,
  output logic                   done,
  output logic      [DVD_W-1:0]  quotient
);

  logic [DVD_W-1:0]  dvd_r;
  logic [DVD_W-1:0]  quo_r;
  logic [SPAN_W-1:0] rem_r;
  logic [SPAN_W-1:0] dvs_r;
  logic [STEP_W-1:0] cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [SPAN_W:0]   rem_sh;
  logic [SPAN_W:0]   rem_sub;
  logic              ge;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign rem_sh  = {rem_r, dvd_r[DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (cmd.start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= cmd.steps;
    end else begin
      done_r <= busy_r && (cnt_r == STEP_W'(1));
      if (busy_r) begin
        cnt_r <= cnt_r - STEP_W'(1);
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DVD_W-2:0], 1'b0};
      rem_r <= ge ? rem_sub[SPAN_W-1:0] : rem_sh[SPAN_W-1:0];
      quo_r <= {quo_r[DVD_W-2:0], ge};
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

>>> design/dsm_sine_rom.sv
`default_nettype none
module dsm_sine_rom import dsm_pkg::*; #(
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  output logic      [15:0]              data
);

  logic [15:0] tab [DEPTH];
  logic [15:0] data_r;

  // Build each quarter-wave entry from a Q30 Taylor series at elaboration
  for (genvar k = 0; k < DEPTH; k++) begin : g_tab
    localparam logic [63:0] X  = (PI_HALF_Q30 * 64'(k)) / 64'(DEPTH);
    localparam logic [63:0] X2 = (X * X) >> 30;
    localparam logic [63:0] T1 = ((X  * X2) >> 30) / 64'd6;
    localparam logic [63:0] S1 = (X >= T1) ? X - T1 : 64'd0;
    localparam logic [63:0] T2 = ((T1 * X2) >> 30) / 64'd20;
    localparam logic [63:0] S2 = S1 + T2;
    localparam logic [63:0] T3 = ((T2 * X2) >> 30) / 64'd42;
    localparam logic [63:0] S3 = (S2 >= T3) ? S2 - T3 : 64'd0;
    localparam logic [63:0] T4 = ((T3 * X2) >> 30) / 64'd72;
    localparam logic [63:0] S4 = S3 + T4;
    localparam logic [63:0] T5 = ((T4 * X2) >> 30) / 64'd110;
    localparam logic [63:0] S5 = (S4 >= T5) ? S4 - T5 : 64'd0;
    localparam logic [63:0] T6 = ((T5 * X2) >> 30) / 64'd156;
    localparam logic [63:0] S6 = S5 + T6;
    localparam logic [63:0] T7 = ((T6 * X2) >> 30) / 64'd210;
    localparam logic [63:0] S7 = (S6 >= T7) ? S6 - T7 : 64'd0;
    localparam logic [63:0] T8 = ((T7 * X2) >> 30) / 64'd272;
    localparam logic [63:0] S8 = S7 + T8;
    localparam logic [63:0] Q  = (S8 + 64'd16384) >> 15;
    localparam logic [63:0] E  = (Q > ONE_Q15) ? ONE_Q15 : Q;
    assign tab[k] = E[15:0];
  end

  // Registered read
  always_ff @(posedge clk) begin
    data_r <= tab[addr];
  end

  assign data = data_r;

endmodule
`default_nettype wire

>>> design/decaying_sine_note_mixer.sv
// Decaying sine note mixer. Each request either reads one 16-bit sample of the mix
// buffer or adds to it one sample of a sine note that decays linearly to zero over
// its length; both return the stored sample and an in-note flag. Requests are
// handled one at a time through a single registered multiplier and a shared
// restoring divider that retires one quotient bit per cycle. A read, or an index
// outside the note, skips both divisions; an update runs the phase division
// (36 + log2(4*SINE_TABLE_DEPTH) steps) and the amplitude division (33 steps). A
// finished result sits in the output register, so the next request is taken while
// it waits. After reset the buffer is cleared one entry a cycle with in_ready low;
// the sample rate register is always ready, and the user must write it only while
// the block is idle; the block itself does not enforce this. SINE_TABLE_DEPTH must
// be a power of two.
`default_nettype none
module decaying_sine_note_mixer import dsm_pkg::*; #(
  parameter int BUFFER_DEPTH     = 65536,
  parameter int SINE_TABLE_DEPTH = 1024
) (
  input wire logic clk,
  input wire logic rst_n,
  dsm_in_if.sink   in_if,
  dsm_out_if.source out_if,
  dsm_cfg_if.sink  cfg_if
);

  localparam int ADDR_W = $clog2(BUFFER_DEPTH);
  localparam int LOG_D  = $clog2(SINE_TABLE_DEPTH);
  localparam int LOG4D  = LOG_D + 2;
  localparam int DVD_W  = PH_PROD_W + LOG4D;

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_FETCH = 12'b000000000100,
    S_PDIV  = 12'b000000001000,
    S_PWAIT = 12'b000000010000,
    S_AMUL  = 12'b000000100000,
    S_VMUL  = 12'b000001000000,
    S_ADIV  = 12'b000010000000,
    S_AWAIT = 12'b000100000000,
    S_DONE  = 12'b001000000000
  } state_t;

  state_t state_r, state_nxt;

  logic [RATE_W-1:0] rate_r;
  logic [ADDR_W-1:0] clr_cnt_r;
  logic [ADDR_W-1:0] addr_r;
  logic [IDX_W-1:0]  n_r;
  logic [LEN_W-1:0]  len_r;
  logic [FREQ_W-1:0] freq_r;
  logic [VEL_W-1:0]  vel_r;
  logic              hit_r;
  logic              inr_r;
  logic              neg_r;
  logic              special_r;
  logic [SMP_W-1:0]  res_r;
  logic [SMP_W-1:0]  rd_data_r;
  logic              out_valid_r;
  logic [SMP_W-1:0]  out_sample_r;
  logic              out_note_r;
  logic [SMP_W-1:0]  mem [BUFFER_DEPTH];

  logic              in_acc;
  logic [IDX_W-1:0]  in_n;
  logic              in_inr;
  logic              in_hit;
  logic [RATE_W-1:0] rate_eff;
  logic [SPAN_W-1:0] span;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] prod;
  div_cmd_t          div_cmd;
  logic [DVD_W-1:0]  div_dvd;
  logic [SPAN_W-1:0] div_dvs;
  logic              div_done;
  logic [DVD_W-1:0]  quo;
  logic [LOG4D-1:0]  pos;
  logic [LOG_D-1:0]  tab_i;
  logic [LOG_D-1:0]  rom_addr;
  logic [15:0]       rom_q;
  logic [15:0]       mag;
  logic [AMP_DVD_W-1:0] amp;
  logic [SMP_W-1:0]  contrib;
  logic [SMP_W-1:0]  sum;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [SMP_W-1:0]  mem_wd;
  logic              out_free;

  // Request decode
  assign in_acc = in_if.valid && in_if.ready;
  assign in_n   = in_if.sample_index - in_if.note_start;
  assign in_inr = {16'b0, in_if.sample_index} < 32'(BUFFER_DEPTH);
  assign in_hit = (in_if.operation == OP_ACCUM) && in_inr
               && (in_if.sample_index >= in_if.note_start)
               && (LEN_W'(in_n) < in_if.note_length);

  assign in_if.ready = (state_r == S_IDLE);
  assign cfg_if.ready = 1'b1;
  assign out_free = !out_valid_r || out_if.ready;

  // Sample rate register, zero acts as one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_r <= RATE_W'(44100);
    end else if (cfg_if.valid) begin
      rate_r <= cfg_if.data;
    end
  end
  assign rate_eff = (rate_r == '0) ? RATE_W'(1) : rate_r;
  assign span     = {rate_eff, 4'b0000};

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_cnt_r == ADDR_W'(BUFFER_DEPTH - 1)) state_nxt = S_IDLE;
      S_IDLE:  if (in_acc) state_nxt = S_FETCH;
      S_FETCH: state_nxt = hit_r ? S_PDIV : S_DONE;
      S_PDIV:  state_nxt = S_PWAIT;
      S_PWAIT: if (div_done) state_nxt = S_AMUL;
      S_AMUL:  state_nxt = S_VMUL;
      S_VMUL:  state_nxt = S_ADIV;
      S_ADIV:  state_nxt = S_AWAIT;
      S_AWAIT: if (div_done) state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
    end
  end

  // Latch the request
  always_ff @(posedge clk) begin
    if (in_acc) begin
      addr_r <= ADDR_W'(in_if.sample_index);
      n_r    <= in_n;
      len_r  <= in_if.note_length;
      freq_r <= in_if.frequency;
      vel_r  <= in_if.velocity;
      hit_r  <= in_hit;
      inr_r  <= in_inr;
    end
  end

  // Shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_FETCH: begin
        mul_a = MUL_A_W'(freq_r);
        mul_b = MUL_B_W'(n_r);
      end
      S_AMUL: begin
        mul_a = MUL_A_W'(mag);
        mul_b = MUL_B_W'(len_r - LEN_W'(n_r));
      end
      S_VMUL: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = MUL_B_W'(vel_r);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  dsm_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  // Shared divider: phase position first, then amplitude
  always_comb begin
    div_cmd.start = 1'b0;
    div_cmd.steps = '0;
    div_dvd       = '0;
    div_dvs       = '0;
    case (state_r)
      S_PDIV: begin
        div_cmd.start = 1'b1;
        div_cmd.steps = STEP_W'(DVD_W);
        div_dvd       = {prod[PH_PROD_W-1:0], {LOG4D{1'b0}}};
        div_dvs       = span;
      end
      S_ADIV: begin
        div_cmd.start = 1'b1;
        div_cmd.steps = STEP_W'(AMP_DVD_W);
        div_dvd       = {prod[AMP_DVD_W+15:16], {(DVD_W-AMP_DVD_W){1'b0}}};
        div_dvs       = SPAN_W'(len_r);
      end
      default: begin
        div_cmd.start = 1'b0;
      end
    endcase
  end

  dsm_div #(.DVD_W(DVD_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (div_cmd),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quotient (quo)
  );

  // Quadrant fold into the quarter-wave table
  assign pos      = quo[LOG4D-1:0];
  assign tab_i    = pos[LOG_D-1:0];
  assign rom_addr = pos[LOG_D] ? (LOG_D'(0) - tab_i) : tab_i;

  dsm_sine_rom #(.DEPTH(SINE_TABLE_DEPTH)) u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_q)
  );

  always_ff @(posedge clk) begin
    if (state_r == S_PWAIT && div_done) begin
      neg_r     <= pos[LOG4D-1];
      special_r <= pos[LOG_D] && (tab_i == '0);
    end
  end
  assign mag = special_r ? SINE_ONE : rom_q;

  // Saturate the contribution and add into the stored sample
  assign amp = quo[AMP_DVD_W-1:0];
  always_comb begin
    if (neg_r) begin
      contrib = (amp > AMP_DVD_W'(32768)) ? SINE_ONE : (SMP_W'(0) - amp[SMP_W-1:0]);
      if (amp > AMP_DVD_W'(32768)) contrib = SINE_ONE;
    end else begin
      contrib = (amp > AMP_DVD_W'(32767)) ? 16'h7FFF : amp[SMP_W-1:0];
    end
  end
  assign sum = rd_data_r + contrib;

  // Buffer memory: clearing pass, then read-modify-write
  assign mem_we = (state_r == S_CLEAR) || (state_r == S_AWAIT && div_done);
  assign mem_wa = (state_r == S_CLEAR) ? clr_cnt_r : addr_r;
  assign mem_wd = (state_r == S_CLEAR) ? '0 : sum;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[addr_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_AWAIT && div_done) begin
      res_r <= sum;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_DONE && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_DONE && out_free) begin
      out_sample_r <= hit_r ? res_r : (inr_r ? rd_data_r : '0);
      out_note_r   <= hit_r;
    end
  end

  assign out_if.valid   = out_valid_r;
  assign out_if.sample  = out_sample_r;
  assign out_if.in_note = out_note_r;

endmodule
`default_nettype wire

>>> design/dsm_chk.sv
`default_nettype none
module dsm_chk import dsm_pkg::*; (
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             in_valid,
  input wire logic             in_ready,
  input wire logic             out_valid,
  input wire logic             out_ready,
  input wire logic [SMP_W-1:0] out_sample,
  input wire logic             out_in_note
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_sample) && $stable(out_in_note)))
    else $error("stalled result changed");

  // Drop ready once a request is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while busy");

  // Reset empties the output and blocks requests
  a_reset: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && !in_ready))
    else $error("activity right after reset");

  // A result never shows up the cycle after a request is taken with no result pending
  a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !out_valid) |=> !out_valid)
    else $error("result appeared too early");

endmodule

bind decaying_sine_note_mixer dsm_chk u_dsm_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .out_sample  (out_if.sample),
  .out_in_note (out_if.in_note)
);
`default_nettype wire

>>> tb/decaying_sine_note_mixer_checker.sv
`timescale 1ns / 100ps
`default_nettype none
module decaying_sine_note_mixer_checker import dsm_pkg::*; (
  input wire logic clk,
  input wire logic rst_n,
  dsm_in_if        in_if,
  dsm_out_if       out_if,
  dsm_cfg_if       cfg_if,
  output int       fail_count,
  output int       pending
);

  localparam int MIX_DEPTH  = 65536;
  localparam int QSIN_DEPTH = 1024;

  typedef struct {
    logic signed [SMP_W-1:0] sample;
    logic                    in_note;
  } mix_result_t;

  logic [SMP_W-1:0]  mix_model [MIX_DEPTH];
  logic [16:0]       qsin [QSIN_DEPTH];
  logic [RATE_W-1:0] rate_reg;
  mix_result_t       result_q [$];

  // Build the quarter-wave table with the same Q30 series as the block
  function automatic void build_qsin();
    longint unsigned x, x2, term, acc, q15;
    for (int k = 0; k < QSIN_DEPTH; k++) begin
      x = (PI_HALF_Q30 * longint'(k)) / QSIN_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      acc = x;
      for (int i = 1; i <= 8; i++) begin
        term = ((term * x2) >> 30) / longint'((2 * i) * (2 * i + 1));
        if (i % 2 == 1) begin
          acc = (acc >= term) ? acc - term : 0;
        end else begin
          acc = acc + term;
        end
      end
      q15 = (acc + 64'd16384) >> 15;
      if (q15 > ONE_Q15) q15 = ONE_Q15;
      qsin[k] = q15[16:0];
    end
  endfunction

  // Signed, saturated note contribution at offset n
  function automatic int note_gain(longint unsigned n, longint unsigned len,
                                   longint unsigned freq, longint unsigned vel);
    longint unsigned rate, span, r, pos, quad, idx, mag, amp;
    rate = (rate_reg == 0) ? 1 : rate_reg;
    span = 16 * rate;
    r = (freq * n) % span;
    pos = (r * 4 * QSIN_DEPTH) / span;
    quad = (pos / QSIN_DEPTH) % 4;
    idx = pos % QSIN_DEPTH;
    if (quad % 2 == 1) begin
      mag = (idx == 0) ? ONE_Q15 : qsin[QSIN_DEPTH - idx];
    end else begin
      mag = qsin[idx];
    end
    amp = (mag * (len - n) * vel) / (len * 65536);
    if (quad >= 2) begin
      if (amp > 32768) amp = 32768;
      return -int'(amp);
    end
    if (amp > 32767) amp = 32767;
    return int'(amp);
  endfunction

  // Apply one request to the buffer copy and return its expected result
  function automatic mix_result_t mix_apply(logic op, logic [IDX_W-1:0] idx,
                                            logic [IDX_W-1:0] start,
                                            logic [LEN_W-1:0] len,
                                            logic [FREQ_W-1:0] freq,
                                            logic [VEL_W-1:0] vel);
    mix_result_t res;
    int          gain;
    res.in_note = 1'b0;
    if (op == OP_ACCUM && idx >= start && longint'(idx - start) < longint'(len)) begin
      gain = note_gain(idx - start, len, freq, vel);
      mix_model[idx] = mix_model[idx] + gain[SMP_W-1:0];
      res.in_note = 1'b1;
    end
    res.sample = mix_model[idx];
    return res;
  endfunction

  initial begin
    build_qsin();
    fail_count = 0;
  end

  assign pending = result_q.size();

  always @(posedge clk) begin
    mix_result_t want;
    if (!rst_n) begin
      result_q.delete();
      rate_reg <= 44100;
      foreach (mix_model[i]) mix_model[i] = '0;
    end else begin
      // Track sample rate writes
      if (cfg_if.valid && cfg_if.ready) rate_reg <= cfg_if.data;
      // Predict each accepted request
      if (in_if.valid && in_if.ready)
        result_q.push_back(mix_apply(in_if.operation, in_if.sample_index,
                                     in_if.note_start, in_if.note_length,
                                     in_if.frequency, in_if.velocity));
      // Compare each accepted result with the oldest prediction
      if (out_if.valid && out_if.ready) begin
        if (result_q.size() == 0) begin
          $display("%0t: unexpected result sample=%0d in_note=%0b", $time,
                   out_if.sample, out_if.in_note);
          fail_count++;
        end else begin
          want = result_q.pop_front();
          if (out_if.sample !== want.sample) begin
            $display("%0t: sample mismatch expected=%0d actual=%0d", $time,
                     want.sample, out_if.sample);
            fail_count++;
          end
          if (out_if.in_note !== want.in_note) begin
            $display("%0t: in_note mismatch expected=%0b actual=%0b", $time,
                     want.in_note, out_if.in_note);
            fail_count++;
          end
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> tb/decaying_sine_note_mixer_tb.sv
`timescale 1ns / 100ps
`default_nettype none
module decaying_sine_note_mixer_tb import dsm_pkg::*;;

  localparam int WATCH_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 150;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   idle_cycles = 0;
  int   hold_asks = 0;
  bit   no_gaps = 1'b0;

  dsm_in_if  in_if ();
  dsm_out_if out_if ();
  dsm_cfg_if cfg_if ();

  decaying_sine_note_mixer dut (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if)
  );

  decaying_sine_note_mixer_checker mix_check (
    .clk(clk), .rst_n(rst_n), .in_if(in_if), .out_if(out_if), .cfg_if(cfg_if),
    .fail_count(fail_count), .pending(pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Offer one request, after a random gap, and hold it until accepted
  task automatic send_req(logic op, logic [IDX_W-1:0] idx, logic [IDX_W-1:0] start,
                          logic [LEN_W-1:0] len, logic [FREQ_W-1:0] freq,
                          logic [VEL_W-1:0] vel);
    int gap;
    gap = no_gaps ? 0 : rand_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.operation = op;
    in_if.sample_index = idx;
    in_if.note_start = start;
    in_if.note_length = len;
    in_if.frequency = freq;
    in_if.velocity = vel;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Drain, let the block settle, then write the sample rate
  task automatic write_rate(logic [RATE_W-1:0] rate);
    @(negedge clk);
    in_if.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
    cfg_if.valid = 1'b1;
    cfg_if.data = rate;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Random request, mostly notes that cover a small buffer window
  task automatic send_random();
    int          r, idx, off, len, start;
    logic        op;
    logic [16:0] vel;
    r = $urandom_range(0, 99);
    if (r < 10) begin
      send_req($urandom_range(0, 1), $urandom, $urandom, $urandom_range(0, 131071),
               $urandom_range(0, 1048575), $urandom_range(0, 131071));
    end else begin
      idx = $urandom_range(0, 63);
      if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, 65535);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 65536)
                                        : $urandom_range(1, 300);
      off = $urandom_range(0, (len < 400) ? len + 2 : 400);
      if ($urandom_range(0, 19) == 0) off = $urandom_range(0, 65535);
      start = (off > idx) ? idx + $urandom_range(0, 3) : idx - off;
      if (start > 65535) start = 65535;
      vel = ($urandom_range(0, 7) == 0) ? 17'd65536 : $urandom_range(0, 65536);
      op = (r < 30) ? OP_READ : OP_ACCUM;
      send_req(op, idx, start, len, $urandom_range(0, 1048575), vel);
    end
  endtask

  // Result side: random stalls plus long hold-offs on request
  initial begin
    int stall, hold, seen;
    stall = 0;
    hold = 0;
    seen = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asks != seen) begin
        seen = hold_asks;
        hold = 800;
      end
      if (hold > 0) begin
        hold--;
        out_if.ready = 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_if.ready = 1'b0;
      end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
        stall = rand_gap();
        out_if.ready = (stall == 0);
      end else begin
        out_if.ready = 1'b1;
      end
    end
  end

  // Watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.operation = OP_ACCUM;
    in_if.sample_index = '0;
    in_if.note_start = '0;
    in_if.note_length = '0;
    in_if.frequency = '0;
    in_if.velocity = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes, quadrant edges, saturation, misses
    send_req(OP_READ, 16'd0, 16'd0, 17'd1, 20'd0, 17'd0);
    send_req(OP_READ, 16'hffff, 16'd0, 17'd1, 20'd0, 17'd0);
    send_req(OP_ACCUM, 16'd0, 16'd0, 17'd1, 20'd1000, 17'd65536);
    send_req(OP_ACCUM, 16'd1, 16'd0, 17'd65536, 20'd176400, 17'd131071);
    send_req(OP_ACCUM, 16'd2, 16'd0, 17'd65536, 20'd176400, 17'd65536);
    send_req(OP_ACCUM, 16'd3, 16'd0, 17'd65536, 20'd176400, 17'd131071);
    send_req(OP_ACCUM, 16'd3, 16'd0, 17'd65536, 20'd176400, 17'd131071);
    send_req(OP_ACCUM, 16'd5, 16'd1, 17'd8, 20'd88200, 17'd65536);
    send_req(OP_ACCUM, 16'd5, 16'd6, 17'd8, 20'd88200, 17'd65536);
    send_req(OP_ACCUM, 16'd9, 16'd1, 17'd8, 20'd88200, 17'd65536);
    send_req(OP_ACCUM, 16'd9, 16'd9, 17'd0, 20'd88200, 17'd65536);
    send_req(OP_ACCUM, 16'hffff, 16'hffff, 17'd1, 20'hfffff, 17'd65536);
    send_req(OP_ACCUM, 16'hffff, 16'd0, 17'h1ffff, 20'hfffff, 17'h1ffff);
    send_req(OP_ACCUM, 16'd7, 16'd0, 17'd10, 20'd0, 17'd65536);
    send_req(OP_ACCUM, 16'd8, 16'd0, 17'd10, 20'd12345, 17'd0);
    send_req(OP_READ, 16'd3, 16'd0, 17'd65536, 20'd176400, 17'd65536);
    send_req(OP_READ, 16'hffff, 16'hffff, 17'h1ffff, 20'hfffff, 17'h1ffff);

    // Random phases over several sample rates
    write_rate(18'd8000);
    for (int i = 0; i < 150; i++) send_random();
    write_rate(18'd192000);
    hold_asks++;
    no_gaps = 1'b1;
    for (int i = 0; i < 150; i++) send_random();
    no_gaps = 1'b0;
    write_rate($urandom_range(8000, 192000));
    for (int i = 0; i < 150; i++) send_random();
    write_rate(18'd44100);
    for (int i = 0; i < 150; i++) send_random();
    @(negedge clk);
    in_if.valid = 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
